// ===== hw/rtl/mtc_pkg.sv =====
package mtc_pkg;

	// Field and datapath widths.
	localparam int TICK_W      = 32;
	localparam int TEMPO_W     = 24;
	localparam int UNIT_W      = 16;
	localparam int FRAME_W     = 5;
	localparam int FRAC_W      = 16;
	localparam int COEF_W      = 48;
	localparam int TIME_W      = 64;
	localparam int DEN_W       = 21;
	localparam int NUM_W       = 41;
	localparam int MUL_CHUNK_W = 16;
	localparam int MUL_STEPS   = 3;
	localparam int PROD_W      = TICK_W + COEF_W;

	// Request codes.
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_PASS   = 2'd2;
	localparam logic [1:0] REQ_EVENT  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK = 2'd2;

	// Fixed values.
	localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = 24'd500000;
	localparam logic [UNIT_W-1:0]  DEFAULT_TICKS = 16'd192;
	// One second in microseconds, scaled by two to the sixteenth.
	localparam logic [NUM_W-1:0]   SMPTE_NUM     = 41'd65536000000;
	// Rate of the default tempo at the default resolution, rounded.
	localparam logic [COEF_W-1:0]  RESET_RATE    = 48'd170666667;
	localparam logic signed [TIME_W-1:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [TIME_W-1:0] TIME_MIN = 64'sh8000_0000_0000_0000;

	// Divider transaction: start strobe with rounded numerator and divisor.
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	// Multiplier transaction: start strobe, sign and operands.
	typedef struct packed {
		logic              start;
		logic              neg;
		logic [TICK_W-1:0] mag;
		logic [COEF_W-1:0] coef;
	} mul_req_t;

endpackage

// ===== hw/rtl/mtc_ram.sv =====
module mtc_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/mtc_div.sv =====
module mtc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mtc_pkg::div_req_t           req,
	output logic                        done,
	output logic [mtc_pkg::COEF_W-1:0]  quot
);
	import mtc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic               active_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   quo_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W:0]     rem_sh;
	logic [DEN_W:0]     rem_diff;
	logic               fits;

	// Restoring division step: bring down one numerator bit and try the divisor.
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign fits     = (rem_sh >= {1'b0, den_q});
	assign rem_diff = rem_sh - {1'b0, den_q};

	// Step counter and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_W'(NUM_W - 1);
			end else if (active_q) begin
				if (cnt_q == '0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operand, remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (active_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = {{(COEF_W - NUM_W){1'b0}}, quo_q};

endmodule

// ===== hw/rtl/mtc_mul.sv =====
module mtc_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mtc_pkg::mul_req_t                 req,
	output logic                              done,
	output logic signed [mtc_pkg::TIME_W-1:0] result
);
	import mtc_pkg::*;

	localparam int CNT_W = $clog2(MUL_STEPS);
	localparam int PP_W  = TICK_W + MUL_CHUNK_W;

	logic                  active_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PROD_W-1:0]     acc_q;
	logic [COEF_W-1:0]     coef_q;
	logic [TICK_W-1:0]     mag_q;
	logic                  neg_q;
	logic [PP_W-1:0]       pp;
	logic                  over;
	logic [TIME_W-1:0]     mag_prod;

	// One 32 by 16 partial product per cycle, top coefficient chunk first.
	assign pp = mag_q * coef_q[COEF_W-1 -: MUL_CHUNK_W];

	// Step counter and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_W'(MUL_STEPS - 1);
			end else if (active_q) begin
				if (cnt_q == '0) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Accumulator shifts by one chunk and adds the next partial product.
	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q  <= '0;
			coef_q <= req.coef;
			mag_q  <= req.mag;
			neg_q  <= req.neg;
		end else if (active_q) begin
			acc_q  <= {acc_q[PROD_W-MUL_CHUNK_W-1:0], {MUL_CHUNK_W{1'b0}}} + PROD_W'(pp);
			coef_q <= {coef_q[COEF_W-MUL_CHUNK_W-1:0], {MUL_CHUNK_W{1'b0}}};
		end
	end

	// Saturate a magnitude above the signed range, then apply the sign.
	assign over     = |acc_q[PROD_W-1:TIME_W-1];
	assign mag_prod = acc_q[TIME_W-1:0];

	always_comb begin
		if (neg_q) begin
			result = over ? TIME_MIN : -$signed(mag_prod);
		end else begin
			result = over ? TIME_MAX : $signed(mag_prod);
		end
	end

	assign done = done_q;

endmodule

// ===== hw/rtl/midi_tempo_map_time_converter_top.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      req_type, onset_ticks, tempo_usec
// result    out        done strobe, one cycle    delta_time, status
// config    in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
// The result strobes as the sequencer returns to idle. Clear and append need
// neither the divider nor the multiplier. Start pass waits on the bit-serial
// divider (41 steps). An SMPTE event runs one division, then one 3-step multiply.
// A metrical event runs one multiply and one rate division per tempo entry
// crossed, then a final multiply.
// Reset clears the tempo map count and the pass state; the map memory needs no
// clearing. Results cannot be held off; cfg_ready is always high.
module midi_tempo_map_time_converter_top #(
	parameter int MAP_DEPTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           req_type,
	input  logic [mtc_pkg::TICK_W-1:0]           onset_ticks,
	input  logic [mtc_pkg::TEMPO_W-1:0]          tempo_usec,
	output logic                                 done,
	output logic signed [mtc_pkg::TIME_W-1:0]    delta_time,
	output logic                                 status,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mtc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mtc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mtc_pkg::*;

	localparam int AW    = $clog2(MAP_DEPTH);
	localparam int CNT_W = $clog2(MAP_DEPTH + 1);
	localparam int ENT_W = TICK_W + TEMPO_W;

	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_PASS_DIV = 12'b0000_0000_0010,
		S_SMP_DIV  = 12'b0000_0000_0100,
		S_SMP_MUL  = 12'b0000_0000_1000,
		S_FETCH    = 12'b0000_0001_0000,
		S_CHECK    = 12'b0000_0010_0000,
		S_SEG_MUL  = 12'b0000_0100_0000,
		S_SEG_ADD  = 12'b0000_1000_0000,
		S_RATE_DIV = 12'b0001_0000_0000,
		S_FIN_MUL  = 12'b0010_0000_0000,
		S_FIN_ADD  = 12'b0100_0000_0000,
		S_CLAMP    = 12'b1000_0000_0000
	} state_t;

	state_t                    state_q;
	logic [UNIT_W-1:0]         ticks_q;
	logic [FRAME_W-1:0]        frames_q;
	logic [TEMPO_W-1:0]        fallback_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          cursor_q;
	logic signed [TIME_W-1:0]  seg_time_q;
	logic [TICK_W-1:0]         seg_ticks_q;
	logic [COEF_W-1:0]         rate_coef_q;
	logic signed [TIME_W-1:0]  prev_time_q;
	logic [TICK_W-1:0]         onset_q;
	logic [TICK_W-1:0]         at_q;
	logic [TEMPO_W-1:0]        tempo_at_q;
	logic signed [TIME_W-1:0]  span_q;
	logic signed [TIME_W-1:0]  now_q;
	logic                      done_q;
	logic signed [TIME_W-1:0]  delta_q;
	logic                      status_q;
	div_req_t                  div_req_q;
	mul_req_t                  mul_req_q;

	logic                      div_done;
	logic [COEF_W-1:0]         div_quot;
	logic                      mul_done;
	logic signed [TIME_W-1:0]  mul_result;
	logic                      accept;
	logic                      map_full;
	logic                      ram_we;
	logic [ENT_W-1:0]          ram_rdata;
	logic [TICK_W-1:0]         rd_onset;
	logic [TEMPO_W-1:0]        rd_tempo;

	// A resolution of zero counts as one tick.
	function automatic logic [UNIT_W-1:0] eff_ticks(input logic [UNIT_W-1:0] ticks);
		return (ticks == '0) ? UNIT_W'(1) : ticks;
	endfunction

	// Rounded division of a tempo by the resolution, with zero-tempo fallback.
	function automatic div_req_t rate_req(input logic [TEMPO_W-1:0] tempo,
	                                      input logic [TEMPO_W-1:0] fallback,
	                                      input logic [UNIT_W-1:0]  ticks);
		logic [TEMPO_W-1:0] t;
		logic [DEN_W-1:0]   den;
		div_req_t           r;
		t = tempo;
		if (t == '0) begin
			t = fallback;
		end
		if (t == '0) begin
			t = DEFAULT_TEMPO;
		end
		den     = DEN_W'(eff_ticks(ticks));
		r.start = 1'b1;
		r.num   = {1'b0, t, {FRAC_W{1'b0}}} + NUM_W'(den >> 1);
		r.den   = den;
		return r;
	endfunction

	// Rounded division of one second by frames times ticks per frame.
	function automatic div_req_t smpte_req(input logic [FRAME_W-1:0] frames,
	                                       input logic [UNIT_W-1:0]  ticks);
		logic [DEN_W-1:0] den;
		div_req_t         r;
		den     = DEN_W'(frames) * DEN_W'(eff_ticks(ticks));
		r.start = 1'b1;
		r.num   = SMPTE_NUM + NUM_W'(den >> 1);
		r.den   = den;
		return r;
	endfunction

	// Signed tick span times a rate.
	function automatic mul_req_t span_req(input logic [TICK_W-1:0] from,
	                                      input logic [TICK_W-1:0] to,
	                                      input logic [COEF_W-1:0] coef);
		mul_req_t r;
		r.start = 1'b1;
		r.coef  = coef;
		if (to >= from) begin
			r.neg = 1'b0;
			r.mag = to - from;
		end else begin
			r.neg = 1'b1;
			r.mag = from - to;
		end
		return r;
	endfunction

	// Signed add that saturates at the ends of the 64-bit range.
	function automatic logic signed [TIME_W-1:0] sat_add(input logic signed [TIME_W-1:0] a,
	                                                     input logic signed [TIME_W-1:0] b);
		logic signed [TIME_W-1:0] sum;
		sum = a + b;
		if ((a[TIME_W-1] == b[TIME_W-1]) && (sum[TIME_W-1] != a[TIME_W-1])) begin
			return b[TIME_W-1] ? TIME_MIN : TIME_MAX;
		end
		return sum;
	endfunction

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && (state_q == S_IDLE);
	assign map_full  = (count_q >= CNT_W'(MAP_DEPTH));
	assign cfg_ready = 1'b1;

	// Tempo map memory: onset and tempo side by side, read at the cursor.
	assign ram_we = accept && (req_type == REQ_APPEND) && !map_full;

	mtc_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAP_DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({onset_ticks, tempo_usec}),
		.raddr (cursor_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign rd_onset = ram_rdata[ENT_W-1 -: TICK_W];
	assign rd_tempo = ram_rdata[TEMPO_W-1:0];

	mtc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	mtc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req_q),
		.done   (mul_done),
		.result (mul_result)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q    <= DEFAULT_TICKS;
			frames_q   <= '0;
			fallback_q <= DEFAULT_TEMPO;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TICKS:    ticks_q    <= cfg_data[UNIT_W-1:0];
				CFG_FRAMES:   frames_q   <= cfg_data[FRAME_W-1:0];
				CFG_FALLBACK: fallback_q <= cfg_data[TEMPO_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: walks the tempo map and drives the shared divider and multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			seg_time_q  <= '0;
			seg_ticks_q <= '0;
			rate_coef_q <= RESET_RATE;
			prev_time_q <= '0;
			onset_q     <= '0;
			at_q        <= '0;
			tempo_at_q  <= '0;
			span_q      <= '0;
			now_q       <= '0;
			done_q      <= 1'b0;
			delta_q     <= '0;
			status_q    <= 1'b0;
			div_req_q   <= '0;
			mul_req_q   <= '0;
		end else begin
			done_q          <= 1'b0;
			div_req_q.start <= 1'b0;
			mul_req_q.start <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						onset_q <= onset_ticks;
						case (req_type)
							REQ_CLEAR: begin
								count_q  <= '0;
								cursor_q <= '0;
								done_q   <= 1'b1;
								delta_q  <= '0;
								status_q <= 1'b0;
							end
							REQ_APPEND: begin
								if (!map_full) begin
									count_q <= count_q + 1'b1;
								end
								done_q   <= 1'b1;
								delta_q  <= '0;
								status_q <= map_full;
							end
							REQ_PASS: begin
								cursor_q    <= '0;
								seg_time_q  <= '0;
								seg_ticks_q <= '0;
								prev_time_q <= '0;
								div_req_q   <= rate_req(DEFAULT_TEMPO, fallback_q, ticks_q);
								state_q     <= S_PASS_DIV;
							end
							default: begin
								if (frames_q != '0) begin
									div_req_q <= smpte_req(frames_q, ticks_q);
									state_q   <= S_SMP_DIV;
								end else begin
									state_q <= S_FETCH;
								end
							end
						endcase
					end
				end
				S_PASS_DIV: begin
					if (div_done) begin
						rate_coef_q <= div_quot;
						done_q      <= 1'b1;
						delta_q     <= '0;
						status_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_SMP_DIV: begin
					if (div_done) begin
						mul_req_q <= span_req('0, onset_q, div_quot);
						state_q   <= S_SMP_MUL;
					end
				end
				S_SMP_MUL: begin
					// Fixed rate: the delta may be negative.
					if (mul_done) begin
						delta_q     <= mul_result - prev_time_q;
						prev_time_q <= mul_result;
						done_q      <= 1'b1;
						status_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_FETCH: begin
					if (cursor_q < count_q) begin
						state_q <= S_CHECK;
					end else begin
						mul_req_q <= span_req(seg_ticks_q, onset_q, rate_coef_q);
						state_q   <= S_FIN_MUL;
					end
				end
				S_CHECK: begin
					// Only entries strictly before the event open a new segment.
					if (rd_onset < onset_q) begin
						at_q       <= rd_onset;
						tempo_at_q <= rd_tempo;
						mul_req_q  <= span_req(seg_ticks_q, rd_onset, rate_coef_q);
						state_q    <= S_SEG_MUL;
					end else begin
						mul_req_q <= span_req(seg_ticks_q, onset_q, rate_coef_q);
						state_q   <= S_FIN_MUL;
					end
				end
				S_SEG_MUL: begin
					if (mul_done) begin
						span_q  <= mul_result;
						state_q <= S_SEG_ADD;
					end
				end
				S_SEG_ADD: begin
					seg_time_q  <= sat_add(seg_time_q, span_q);
					seg_ticks_q <= at_q;
					div_req_q   <= rate_req(tempo_at_q, fallback_q, ticks_q);
					state_q     <= S_RATE_DIV;
				end
				S_RATE_DIV: begin
					if (div_done) begin
						rate_coef_q <= div_quot;
						cursor_q    <= cursor_q + 1'b1;
						state_q     <= S_FETCH;
					end
				end
				S_FIN_MUL: begin
					if (mul_done) begin
						span_q  <= mul_result;
						state_q <= S_FIN_ADD;
					end
				end
				S_FIN_ADD: begin
					now_q   <= sat_add(seg_time_q, span_q);
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					// Time never runs backwards in metrical mode.
					if (now_q < prev_time_q) begin
						delta_q <= '0;
					end else begin
						delta_q     <= now_q - prev_time_q;
						prev_time_q <= now_q;
					end
					done_q   <= 1'b1;
					status_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign delta_time = delta_q;
	assign status     = status_q;

	// The walk never passes the end of the filled map.
	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("tempo map cursor beyond entry count");

	// The fill count stays within the memory.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAP_DEPTH))
		else $error("tempo map count beyond depth");

	// A result only appears as the sequencer returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while sequencer busy");

endmodule

// ===== tb/midi_tempo_map_time_converter_top_tb.sv =====
`timescale 1ns / 1ps

// One expected converter result: the event delta and the map-full flag.
typedef struct {
	logic signed [63:0] delta;
	logic               status;
} time_result_t;

// Tracks the tempo map and pass state of the converter and checks its results.
class delta_time_scoreboard;
	int                depth;
	bit [15:0]         ticks_reg;
	bit [4:0]          frames_reg;
	bit [23:0]         fallback_reg;
	bit [31:0]         entry_onset [];
	bit [23:0]         entry_tempo [];
	int                entries;
	int                cursor;
	longint            seg_time;
	bit [31:0]         seg_ticks;
	longint unsigned   coef;
	longint            prev_time;
	time_result_t      due_times [$];
	int                mismatches;
	int                matched;
	int                requests;
	int                events;
	int                smpte_events;
	int                clamps;
	int                full_drops;

	function new(int map_depth);
		depth        = map_depth;
		entry_onset  = new[map_depth];
		entry_tempo  = new[map_depth];
		ticks_reg    = mtc_pkg::DEFAULT_TICKS;
		frames_reg   = '0;
		fallback_reg = mtc_pkg::DEFAULT_TEMPO;
		entries      = 0;
		restart();
	endfunction

	// A new pass starts at tick zero with the default tempo, not the fallback.
	function void restart();
		cursor    = 0;
		seg_time  = 0;
		seg_ticks = '0;
		prev_time = 0;
		coef      = tick_rate(mtc_pkg::DEFAULT_TEMPO);
	endfunction

	function longint unsigned unit_ticks();
		return (ticks_reg == 0) ? 64'd1 : {48'd0, ticks_reg};
	endfunction

	function longint unsigned round_quot(longint unsigned num, longint unsigned den);
		return (num + den / 2) / den;
	endfunction

	// Q.16 microseconds per tick; a zero tempo falls back to the register, then the default.
	function longint unsigned tick_rate(bit [23:0] tempo);
		longint unsigned t;
		t = {40'd0, tempo};
		if (t == 0)
			t = {40'd0, fallback_reg};
		if (t == 0)
			t = {40'd0, mtc_pkg::DEFAULT_TEMPO};
		return round_quot(t << 16, unit_ticks());
	endfunction

	function longint unsigned frame_rate();
		return round_quot(64'd1000000 << 16, {59'd0, frames_reg} * unit_ticks());
	endfunction

	// Signed product of a tick count and a rate, saturated to 64 bits.
	function longint scaled(longint unsigned mag, bit neg, longint unsigned c);
		longint unsigned p;
		if (c != 0 && mag > 64'h7FFF_FFFF_FFFF_FFFF / c)
			return neg ? mtc_pkg::TIME_MIN : mtc_pkg::TIME_MAX;
		p = mag * c;
		return neg ? -longint'(p) : longint'(p);
	endfunction

	function longint sum_sat(longint a, longint b);
		if (b > 0 && a > mtc_pkg::TIME_MAX - b)
			return mtc_pkg::TIME_MAX;
		if (b < 0 && a < mtc_pkg::TIME_MIN - b)
			return mtc_pkg::TIME_MIN;
		return a + b;
	endfunction

	function longint span(bit [31:0] from, bit [31:0] to, longint unsigned c);
		if (to >= from)
			return scaled({32'd0, to - from}, 1'b0, c);
		return scaled({32'd0, from - to}, 1'b1, c);
	endfunction

	function void set_register(logic [1:0] idx, logic [23:0] data);
		case (idx)
			mtc_pkg::CFG_TICKS:    ticks_reg = data[15:0];
			mtc_pkg::CFG_FRAMES:   frames_reg = data[4:0];
			mtc_pkg::CFG_FALLBACK: fallback_reg = data;
			default: ;
		endcase
	endfunction

	// Applies one accepted request and queues the result it must produce.
	function void note_request(logic [1:0] req, logic [31:0] onset, logic [23:0] tempo);
		time_result_t r;
		longint       now;
		r.delta  = '0;
		r.status = 1'b0;
		requests++;
		case (req)
			mtc_pkg::REQ_CLEAR: begin
				entries = 0;
				cursor  = 0;
			end
			mtc_pkg::REQ_APPEND: begin
				if (entries < depth) begin
					entry_onset[entries] = onset;
					entry_tempo[entries] = tempo;
					entries++;
				end else begin
					r.status = 1'b1;
					full_drops++;
				end
			end
			mtc_pkg::REQ_PASS: restart();
			default: begin
				events++;
				if (frames_reg != 0) begin
					// Fixed frame rate; the delta may go negative.
					now = scaled({32'd0, onset}, 1'b0, frame_rate());
					smpte_events++;
				end else begin
					// Walk the tempo entries in order while each starts strictly before the event.
					while (cursor < entries && entry_onset[cursor] < onset) begin
						seg_time  = sum_sat(seg_time, span(seg_ticks, entry_onset[cursor], coef));
						seg_ticks = entry_onset[cursor];
						coef      = tick_rate(entry_tempo[cursor]);
						cursor++;
					end
					now = sum_sat(seg_time, span(seg_ticks, onset, coef));
					if (now < prev_time) begin
						now = prev_time;
						clamps++;
					end
				end
				r.delta   = now - prev_time;
				prev_time = now;
			end
		endcase
		due_times.push_back(r);
	endfunction

	function void report(string what, time_result_t want, logic [63:0] delta, logic status);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected delta %0d status %0d, got delta %0d status %0d",
				$realtime, what, want.delta, want.status, $signed(delta), status);
	endfunction

	// Compares one strobed result with the oldest pending expectation.
	function void check_result(logic [63:0] delta, logic status);
		time_result_t want;
		if (due_times.size() == 0) begin
			want.delta  = 'x;
			want.status = 1'bx;
			report("unexpected result", want, delta, status);
			return;
		end
		want = due_times.pop_front();
		if (delta !== want.delta || status !== want.status)
			report("result mismatch", want, delta, status);
		else
			matched++;
	endfunction

	function int outstanding();
		return due_times.size();
	endfunction

	function int failures();
		return mismatches + due_times.size();
	endfunction
endclass

module midi_tempo_map_time_converter_top_tb;
	localparam int MAP_DEPTH       = 32;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int PHASES          = 8;
	localparam int SETTLE_CYCLES   = 120;
	localparam int CYCLE_LIMIT     = 10_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = mtc_pkg::REQ_CLEAR;
	logic [31:0] onset_ticks = '0;
	logic [23:0] tempo_usec = '0;
	logic        done;
	logic signed [63:0] delta_time;
	logic        status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = mtc_pkg::CFG_TICKS;
	logic [23:0] cfg_data = '0;

	delta_time_scoreboard sb = new(MAP_DEPTH);

	int cycle_count = 0;
	int idle_pct = 0;
	int phase_items = 0;
	int drains = 0;

	// Register settings and sender idling for each phase; phase 0 keeps the reset values.
	logic [15:0] phase_ticks    [PHASES] = '{16'd192, 16'd1, 16'd65535, 16'd0,
		16'd65535, 16'd480, 16'd0, 16'd192};
	logic [4:0]  phase_frames   [PHASES] = '{5'd0, 5'd0, 5'd0, 5'd30, 5'd31, 5'd25, 5'd0, 5'd0};
	logic [23:0] phase_fallback [PHASES] = '{24'd500000, 24'd0, 24'hFFFFFF, 24'd1,
		24'd500000, 24'd0, 24'd0, 24'd500000};
	int          phase_idle     [PHASES] = '{0, 74, 27, 0, 74, 27, 0, 74};

	midi_tempo_map_time_converter_top #(
		.MAP_DEPTH(MAP_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.onset_ticks(onset_ticks),
		.tempo_usec(tempo_usec),
		.done(done),
		.delta_time(delta_time),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Every strobed result is a completed transaction.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(delta_time, status);
	end

	// Watchdog for a hung converter.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Lowers start and waits until every pending result has been strobed.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	// Drives one request transaction, then idles the sender at random.
	task automatic issue(input logic [1:0] req, input logic [31:0] onset,
		input logic [23:0] tempo);
		int gap;
		bit pause;
		req_type    <= req;
		onset_ticks <= onset;
		tempo_usec  <= tempo;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(req, onset, tempo);
		phase_items++;
		gap = 0;
		while (gap < 12 && $urandom_range(99) < idle_pct)
			gap++;
		pause = ($urandom_range(149) == 0);
		if (pause) begin
			drain();
			drains++;
		end
		if (gap > 0) begin
			if (!pause)
				start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Writes all three registers once the converter has gone idle.
	task automatic program_phase(input logic [15:0] t, input logic [4:0] f,
		input logic [23:0] fb);
		logic [1:0]  idxs [3];
		logic [23:0] vals [3];
		idxs = '{mtc_pkg::CFG_TICKS, mtc_pkg::CFG_FRAMES, mtc_pkg::CFG_FALLBACK};
		vals = '{{8'($urandom()), t}, {19'($urandom()), f}, fb};
		drain();
		while (busy) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_index <= idxs[i];
			cfg_data  <= vals[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			sb.set_register(idxs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] pick_tempo();
		case ($urandom_range(9))
			0: return 24'd0;
			1: return 24'($urandom_range(0, 24'hFFFFFF));
			2: return 24'hFFFFFF;
			3: return 24'd1;
			default: return 24'($urandom_range(250000, 1000000));
		endcase
	endfunction

	function automatic logic [31:0] stride();
		if ($urandom_range(9) == 0)
			return $urandom_range(0, 32'h00FF_FFFF);
		return $urandom_range(0, 3000);
	endfunction

	// A typical song: usually a clear, a mostly sorted tempo map, usually a new pass, then a run of events.
	task automatic play_song(input bit oversize);
		int          n;
		int          m;
		logic [31:0] at;
		logic [31:0] pos;
		logic [31:0] onsets [$];
		if (oversize || $urandom_range(9) != 0)
			issue(mtc_pkg::REQ_CLEAR, $urandom(), 24'($urandom()));
		if (oversize)
			n = $urandom_range(MAP_DEPTH + 1, MAP_DEPTH + 4);
		else if ($urandom_range(4) == 0)
			n = $urandom_range(8, MAP_DEPTH);
		else
			n = $urandom_range(0, 6);
		at = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(0, 2000);
		for (int i = 0; i < n; i++) begin
			// Now and then an entry lands below the previous one.
			if ($urandom_range(14) == 0)
				at = at - $urandom_range(0, 4000);
			issue(mtc_pkg::REQ_APPEND, at, pick_tempo());
			onsets.push_back(at);
			at = at + stride();
		end
		if ($urandom_range(7) != 0)
			issue(mtc_pkg::REQ_PASS, $urandom(), 24'($urandom()));
		m   = $urandom_range(1, 8);
		pos = '0;
		for (int j = 0; j < m; j++) begin
			case ($urandom_range(9))
				0: pos = pos - $urandom_range(0, 3000);
				1: pos = $urandom();
				2: if (onsets.size() > 0)
					pos = onsets[$urandom_range(0, onsets.size() - 1)];
				default: pos = pos + stride() + $urandom_range(0, 2000);
			endcase
			issue(mtc_pkg::REQ_EVENT, pos, 24'($urandom()));
		end
	endtask

	task automatic random_traffic();
		while (phase_items < ITEMS_PER_PHASE) begin
			if ($urandom_range(6) == 0)
				issue(2'($urandom_range(0, 3)), $urandom(), 24'($urandom()));
			else
				play_song(1'b0);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset settings.
		issue(mtc_pkg::REQ_EVENT, 32'd100, 24'd0);
		issue(mtc_pkg::REQ_PASS, 32'hFFFF_FFFF, 24'hFFFFFF);
		issue(mtc_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 24'hFFFFFF);
		issue(mtc_pkg::REQ_APPEND, 32'd0, 24'd0);
		issue(mtc_pkg::REQ_APPEND, 32'd1000, 24'hFFFFFF);
		issue(mtc_pkg::REQ_APPEND, 32'd500, 24'd1);
		issue(mtc_pkg::REQ_APPEND, 32'd2000, 24'd600000);
		issue(mtc_pkg::REQ_EVENT, 32'd0, 24'd0);
		issue(mtc_pkg::REQ_EVENT, 32'd1000, 24'd0);
		issue(mtc_pkg::REQ_EVENT, 32'd1001, 24'hFFFFFF);
		issue(mtc_pkg::REQ_EVENT, 32'd600, 24'd0);
		issue(mtc_pkg::REQ_EVENT, 32'd2500, 24'd0);
		issue(mtc_pkg::REQ_EVENT, 32'hFFFF_FFFF, 24'd0);
		issue(mtc_pkg::REQ_PASS, 32'd0, 24'd0);
		issue(mtc_pkg::REQ_EVENT, 32'hFFFF_FFFF, 24'd0);
		issue(mtc_pkg::REQ_CLEAR, 32'd0, 24'd0);
		issue(mtc_pkg::REQ_APPEND, 32'hFFFF_FFFF, 24'hFFFFFF);
		issue(mtc_pkg::REQ_EVENT, 32'hFFFF_FFFF, 24'd0);
		issue(mtc_pkg::REQ_EVENT, 32'd5, 24'd0);
		play_song(1'b1);
		random_traffic();

		// Later phases change the registers mid-pass, then run random songs.
		for (int p = 1; p < PHASES; p++) begin
			if (p == 6)
				program_phase(16'($urandom_range(0, 65535)),
					$urandom_range(1) ? 5'd0 : 5'($urandom_range(1, 30)),
					24'($urandom_range(0, 24'hFFFFFF)));
			else
				program_phase(phase_ticks[p], phase_frames[p], phase_fallback[p]);
			idle_pct    = phase_idle[p];
			phase_items = 0;
			issue(mtc_pkg::REQ_EVENT, $urandom_range(0, 5000), 24'd0);
			random_traffic();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d requests over %0d register settings: %0d events, %0d in SMPTE mode,",
			sb.requests, PHASES, sb.events, sb.smpte_events);
		$display("%0d clamped times, %0d map-full drops, %0d idle drains; %0d results matched.",
			sb.clamps, sb.full_drops, drains, sb.matched);
		if (sb.failures() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/mtc_pkg.sv
hw/rtl/mtc_ram.sv
hw/rtl/mtc_div.sv
hw/rtl/mtc_mul.sv
hw/rtl/midi_tempo_map_time_converter_top.sv
tb/midi_tempo_map_time_converter_top_tb.sv
